// ===== design/bis_pkg.sv =====
// Package for the bilinear image sampler: field widths, codes, reset values
// and the helper that sizes the command word. No dependencies.
`default_nettype none

package bis_pkg;

    // Fixed field widths
    localparam int OPCODE_W   = 1;
    localparam int LD_ADDR_W  = 16;
    localparam int PIXEL_W    = 32;
    localparam int POS_W      = 18;
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 4;
    localparam int DIM_W      = 9;
    localparam int CCOUNT_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // Parameter defaults
    localparam int MAX_ROWS_DEF      = 256;
    localparam int MAX_COLS_DEF      = 256;
    localparam int FRACTION_BITS_DEF = 8;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_LOAD   = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_SAMPLE = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd2;

    // Register reset values
    localparam logic [DIM_W-1:0]    HEIGHT_RST   = 9'd256;
    localparam logic [DIM_W-1:0]    WIDTH_RST    = 9'd256;
    localparam logic [CCOUNT_W-1:0] CHANNELS_RST = 3'd4;

    // Queue status
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Width of a command word: sample flag, write enable, four store
    // addresses, pixel word, two fractions.
    function automatic int f_cmd_bits(input int addr_w, input int frac_w);
        return 2 + 4 * addr_w + PIXEL_W + 2 * frac_w;
    endfunction

endpackage

`default_nettype wire

// ===== design/bis_if.sv =====
// Handshake interfaces of the sampler: input words, result words and the
// register write channel. Depends on bis_pkg.
`default_nettype none

interface bis_in_if;
    logic                                valid;
    logic                                ready;
    logic [bis_pkg::OPCODE_W-1:0]        opcode;
    logic [bis_pkg::LD_ADDR_W-1:0]       load_address;
    logic [bis_pkg::PIXEL_W-1:0]         load_pixel;
    logic signed [bis_pkg::POS_W-1:0]    row_position;
    logic signed [bis_pkg::POS_W-1:0]    col_position;

    modport source (output valid, opcode, load_address, load_pixel, row_position,
                    col_position, input ready);
    modport sink   (input valid, opcode, load_address, load_pixel, row_position,
                    col_position, output ready);
endinterface

interface bis_out_if;
    logic                          valid;
    logic                          ready;
    logic [bis_pkg::CHAN_W-1:0]    channel0;
    logic [bis_pkg::CHAN_W-1:0]    channel1;
    logic [bis_pkg::CHAN_W-1:0]    channel2;
    logic [bis_pkg::CHAN_W-1:0]    channel3;

    modport source (output valid, channel0, channel1, channel2, channel3, input ready);
    modport sink   (input valid, channel0, channel1, channel2, channel3, output ready);
endinterface

interface bis_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [bis_pkg::CFG_IDX_W-1:0]     index;
    logic [bis_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/bis_axis.sv =====
// One axis of the sample position: limits the dimension, clamps the position
// and splits it into base index, neighbour index and fraction. Uses bis_pkg.
`default_nettype none

module bis_axis #(
    parameter int DIM_MAX = bis_pkg::MAX_ROWS_DEF,
    parameter int FRAC_W  = bis_pkg::FRACTION_BITS_DEF
) (
    input  wire logic [bis_pkg::DIM_W-1:0]        i_dim,
    input  wire logic signed [bis_pkg::POS_W-1:0] i_pos,
    output logic [$clog2(DIM_MAX)-1:0]            o_lo,
    output logic [$clog2(DIM_MAX)-1:0]            o_hi,
    output logic [FRAC_W-1:0]                     o_frac
);

    localparam int IDX_W = $clog2(DIM_MAX);
    localparam int UW    = IDX_W + FRAC_W;
    localparam int CW    = (UW + 1 > bis_pkg::POS_W) ? UW + 1 : bis_pkg::POS_W;

    logic [IDX_W-1:0]     top_idx;
    logic [UW-1:0]        top_pos;
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] top_x;
    logic [UW-1:0]        pos_c;

    // Last usable index, with the dimension held to 2..DIM_MAX
    always_comb begin
        if (i_dim < bis_pkg::DIM_W'(2)) begin
            top_idx = IDX_W'(1);
        end else if (32'(i_dim) > DIM_MAX) begin
            top_idx = IDX_W'(DIM_MAX - 1);
        end else begin
            top_idx = IDX_W'(i_dim - bis_pkg::DIM_W'(1));
        end
    end

    assign top_pos = {top_idx, FRAC_W'(0)};
    assign pos_x   = CW'(i_pos);
    assign top_x   = CW'({1'b0, top_pos});

    always_comb begin
        if (pos_x[CW-1]) begin
            pos_c = '0;
        end else if (pos_x > top_x) begin
            pos_c = top_pos;
        end else begin
            pos_c = pos_x[UW-1:0];
        end
    end

    assign o_lo   = pos_c[UW-1:FRAC_W];
    assign o_frac = pos_c[FRAC_W-1:0];
    // at the far edge the neighbour is the pixel itself (fraction is 0 there)
    assign o_hi   = (o_lo == top_idx) ? o_lo : o_lo + IDX_W'(1);

endmodule

`default_nettype wire

// ===== design/bis_front.sv =====
// Front end: takes input words, classifies load or sample, works out store
// addresses and fractions, and pushes a command word. Uses bis_pkg, bis_axis.
`default_nettype none

module bis_front #(
    parameter int MAX_ROWS      = bis_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS      = bis_pkg::MAX_COLS_DEF,
    parameter int FRACTION_BITS = bis_pkg::FRACTION_BITS_DEF,
    parameter int CMD_W         = bis_pkg::f_cmd_bits($clog2(MAX_ROWS * MAX_COLS),
                                                      FRACTION_BITS)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    bis_in_if.sink                          i_in,
    input  wire logic [bis_pkg::DIM_W-1:0]  i_height,
    input  wire logic [bis_pkg::DIM_W-1:0]  i_width,
    input  wire bis_pkg::t_q_stat           i_q_stat,
    output logic                            o_push,
    output logic [CMD_W-1:0]                o_cmd
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int RIDX_W = $clog2(MAX_ROWS);
    localparam int CIDX_W = $clog2(MAX_COLS);

    typedef struct packed {
        logic                          sample;
        logic                          wr_en;
        logic [ADDR_W-1:0]             a00;
        logic [ADDR_W-1:0]             a01;
        logic [ADDR_W-1:0]             a10;
        logic [ADDR_W-1:0]             a11;
        logic [bis_pkg::PIXEL_W-1:0]   pixel;
        logic [FRACTION_BITS-1:0]      fr;
        logic [FRACTION_BITS-1:0]      fc;
    } t_cmd;

    logic [RIDX_W-1:0]        r0, r1;
    logic [CIDX_W-1:0]        c0, c1;
    logic [FRACTION_BITS-1:0] fr, fc;
    logic [ADDR_W+bis_pkg::LD_ADDR_W-1:0] ld_wide;
    logic                     in_take;
    t_cmd                     n_cmd;
    t_cmd                     r_cmd;
    logic                     r_valid;

    bis_axis #(.DIM_MAX(MAX_ROWS), .FRAC_W(FRACTION_BITS)) u_row (
        .i_dim (i_height),
        .i_pos (i_in.row_position),
        .o_lo  (r0),
        .o_hi  (r1),
        .o_frac(fr)
    );

    bis_axis #(.DIM_MAX(MAX_COLS), .FRAC_W(FRACTION_BITS)) u_col (
        .i_dim (i_width),
        .i_pos (i_in.col_position),
        .o_lo  (c0),
        .o_hi  (c1),
        .o_frac(fc)
    );

    assign ld_wide = {ADDR_W'(0), i_in.load_address};

    always_comb begin
        n_cmd        = '0;
        n_cmd.sample = (i_in.opcode == bis_pkg::OP_SAMPLE);
        n_cmd.pixel  = i_in.load_pixel;
        n_cmd.fr     = fr;
        n_cmd.fc     = fc;
        n_cmd.a01    = ADDR_W'(r0) * ADDR_W'(MAX_COLS) + ADDR_W'(c1);
        n_cmd.a10    = ADDR_W'(r1) * ADDR_W'(MAX_COLS) + ADDR_W'(c0);
        n_cmd.a11    = ADDR_W'(r1) * ADDR_W'(MAX_COLS) + ADDR_W'(c1);
        if (n_cmd.sample) begin
            n_cmd.a00 = ADDR_W'(r0) * ADDR_W'(MAX_COLS) + ADDR_W'(c0);
        end else begin
            // writes beyond the store are dropped
            n_cmd.wr_en = (32'(i_in.load_address) < DEPTH);
            n_cmd.a00   = ld_wide[ADDR_W-1:0];
        end
    end

    assign i_in.ready = !r_valid || !i_q_stat.full;
    assign in_take    = i_in.valid && i_in.ready;
    assign o_push     = r_valid && !i_q_stat.full;
    assign o_cmd      = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== design/bis_queue.sv =====
// Short command queue between front and back end. Uses bis_pkg.
`default_nettype none

module bis_queue #(
    parameter int DW    = 8,
    parameter int DEPTH = bis_pkg::QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire logic [DW-1:0]   i_data,
    input  wire logic            i_pop,
    output logic [DW-1:0]        o_data,
    output bis_pkg::t_q_stat     o_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DW-1:0]    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/bis_back.sv =====
// Back end: pixel store (two copies, two read ports each), weights,
// products, sums and the output register. Uses bis_pkg and bis_out_if.
`default_nettype none

module bis_back #(
    parameter int MAX_ROWS      = bis_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS      = bis_pkg::MAX_COLS_DEF,
    parameter int FRACTION_BITS = bis_pkg::FRACTION_BITS_DEF,
    parameter int CMD_W         = bis_pkg::f_cmd_bits($clog2(MAX_ROWS * MAX_COLS),
                                                      FRACTION_BITS)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [CMD_W-1:0]              i_cmd,
    input  wire bis_pkg::t_q_stat              i_q_stat,
    input  wire logic [bis_pkg::CCOUNT_W-1:0]  i_channels,
    output logic                               o_pop,
    bis_out_if.source                          o_out
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int F      = FRACTION_BITS;
    localparam int W_W    = 2 * F + 1;
    localparam int P_W    = W_W + bis_pkg::CHAN_W;
    localparam int S_W    = P_W + 2;
    localparam int NC     = bis_pkg::NUM_CHAN;

    typedef struct packed {
        logic                          sample;
        logic                          wr_en;
        logic [ADDR_W-1:0]             a00;
        logic [ADDR_W-1:0]             a01;
        logic [ADDR_W-1:0]             a10;
        logic [ADDR_W-1:0]             a11;
        logic [bis_pkg::PIXEL_W-1:0]   pixel;
        logic [F-1:0]                  fr;
        logic [F-1:0]                  fc;
    } t_cmd;

    localparam logic [F:0] ONE = {1'b1, F'(0)};

    t_cmd                         cmd;
    logic                         en;
    logic                         take_sample;
    logic [F:0]                   fr_inv, fc_inv;

    logic [bis_pkg::PIXEL_W-1:0]  mem_a [DEPTH];
    logic [bis_pkg::PIXEL_W-1:0]  mem_b [DEPTH];

    logic [bis_pkg::PIXEL_W-1:0]  r_px [4];
    logic [W_W-1:0]               r_w  [4];
    logic                         r1_valid;
    logic [P_W-1:0]               r_prod [NC][4];
    logic                         r2_valid;
    logic [bis_pkg::CHAN_W-1:0]   n_ch [NC];
    logic [bis_pkg::CHAN_W-1:0]   r_ch [NC];
    logic                         r_out_valid;

    assign cmd         = t_cmd'(i_cmd);
    // whole pipe moves when the output register is free or being emptied
    assign en          = !r_out_valid || o_out.ready;
    assign o_pop       = en && !i_q_stat.empty;
    assign take_sample = o_pop && cmd.sample;

    assign fr_inv = ONE - {1'b0, cmd.fr};
    assign fc_inv = ONE - {1'b0, cmd.fc};

    // Store: both copies take every write; copy a serves the base row,
    // copy b the neighbour row.
    always_ff @(posedge i_clk) begin
        if (o_pop && !cmd.sample && cmd.wr_en) begin
            mem_a[cmd.a00] <= cmd.pixel;
            mem_b[cmd.a00] <= cmd.pixel;
        end
        if (take_sample) begin
            r_px[0] <= mem_a[cmd.a00];
            r_px[1] <= mem_a[cmd.a01];
            r_px[2] <= mem_b[cmd.a10];
            r_px[3] <= mem_b[cmd.a11];
        end
    end

    // Stage 1: weights
    always_ff @(posedge i_clk) begin
        if (take_sample) begin
            r_w[0] <= W_W'(fr_inv) * W_W'(fc_inv);
            r_w[1] <= W_W'(fr_inv) * W_W'(cmd.fc);
            r_w[2] <= W_W'(cmd.fr) * W_W'(fc_inv);
            r_w[3] <= W_W'(cmd.fr) * W_W'(cmd.fc);
        end
    end

    // Stage 2: one product per channel and neighbour
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int ch = 0; ch < NC; ch++) begin
                for (int n = 0; n < 4; n++) begin
                    r_prod[ch][n] <= P_W'(r_px[n][8*ch +: 8]) * P_W'(r_w[n]);
                end
            end
        end
    end

    // Stage 3: sum, drop fraction, limit, blank unused channels
    always_comb begin
        logic [S_W-1:0] sum;
        logic [S_W-1:0] val;
        for (int ch = 0; ch < NC; ch++) begin
            sum = S_W'(r_prod[ch][0]) + S_W'(r_prod[ch][1])
                + S_W'(r_prod[ch][2]) + S_W'(r_prod[ch][3]);
            val = sum >> (2 * F);
            if (bis_pkg::CCOUNT_W'(ch) >= i_channels) begin
                n_ch[ch] = '0;
            end else if (val > S_W'(255)) begin
                n_ch[ch] = 8'hFF;
            end else begin
                n_ch[ch] = val[bis_pkg::CHAN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ch <= n_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r1_valid    <= take_sample;
            r2_valid    <= r1_valid;
            r_out_valid <= r2_valid;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.channel0 = r_ch[0];
    assign o_out.channel1 = r_ch[1];
    assign o_out.channel2 = r_ch[2];
    assign o_out.channel3 = r_ch[3];

endmodule

`default_nettype wire

// ===== design/bilinear_image_sampler_unit.sv =====
// Bilinear image sampler: a pixel store of MAX_ROWS x MAX_COLS words with up
// to four 8-bit channels each. A load word (opcode 0) writes load_pixel at
// load_address (row * MAX_COLS + column; addresses past the store are
// dropped) and gives no result. A sample word (opcode 1) carries a signed row
// and column position with FRACTION_BITS fraction bits; the position is
// clamped into the configured image, the four surrounding pixels are read
// and each channel is blended with fixed-point weights, truncated and held to
// 0..255; channels at or above channel_count read as 0. One word is taken
// every cycle as long as results are drained; a result passes through the
// input register, queue, store read with weights, products, and sums into the
// output register. The store is two copies with two read ports each, so
// all four neighbours are read in the same cycle. Pixels must be loaded
// before they are sampled; the store is not cleared at reset. Registers must
// be written only while the block is idle; the block does not enforce this.
// Depends on bis_pkg, bis_if, bis_axis, bis_front, bis_queue, bis_back.
`default_nettype none

module bilinear_image_sampler_unit #(
    parameter int MAX_ROWS      = bis_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS      = bis_pkg::MAX_COLS_DEF,
    parameter int FRACTION_BITS = bis_pkg::FRACTION_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bis_in_if.sink    i_in,
    bis_out_if.source o_out,
    bis_cfg_if.sink   i_cfg
);

    localparam int ADDR_W = $clog2(MAX_ROWS * MAX_COLS);
    localparam int CMD_W  = bis_pkg::f_cmd_bits(ADDR_W, FRACTION_BITS);

    // Registers
    logic [bis_pkg::DIM_W-1:0]    r_height;
    logic [bis_pkg::DIM_W-1:0]    r_width;
    logic [bis_pkg::CCOUNT_W-1:0] r_channels;

    // Front to back through the queue
    logic                         q_push;
    logic                         q_pop;
    logic [CMD_W-1:0]             q_in;
    logic [CMD_W-1:0]             q_out;
    bis_pkg::t_q_stat             q_stat;

    // Register port never stalls
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height   <= bis_pkg::HEIGHT_RST;
            r_width    <= bis_pkg::WIDTH_RST;
            r_channels <= bis_pkg::CHANNELS_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                bis_pkg::CFG_HEIGHT:   r_height   <= i_cfg.data;
                bis_pkg::CFG_WIDTH:    r_width    <= i_cfg.data;
                bis_pkg::CFG_CHANNELS: r_channels <= i_cfg.data[bis_pkg::CCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Front: classify words, clamp and split positions, form store addresses
    bis_front #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_COLS     (MAX_COLS),
        .FRACTION_BITS(FRACTION_BITS),
        .CMD_W        (CMD_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_height(r_height),
        .i_width (r_width),
        .i_q_stat(q_stat),
        .o_push  (q_push),
        .o_cmd   (q_in)
    );

    // Short queue so that front and back stall on their own
    bis_queue #(
        .DW   (CMD_W),
        .DEPTH(bis_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_in),
        .i_pop  (q_pop),
        .o_data (q_out),
        .o_stat (q_stat)
    );

    // Back: store writes and reads, blending pipeline, output register
    bis_back #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_COLS     (MAX_COLS),
        .FRACTION_BITS(FRACTION_BITS),
        .CMD_W        (CMD_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (q_out),
        .i_q_stat  (q_stat),
        .i_channels(r_channels),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

`ifndef SYNTH
    // front never overruns the queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("command pushed into full queue");

    // back never takes from an empty queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("command popped from empty queue");

    // a push without a pop leaves the queue non-empty next cycle
    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && !q_pop) |=> !q_stat.empty)
        else $error("queue empty after push");
`endif

endmodule

`default_nettype wire
